@@ hw/rtl/lsar_pkg.sv @@
// Shared types, constants and helper functions for the light sensor auto-ranging block.
package lsar_pkg;

  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IR_FACTOR        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_FACTOR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAINT_LEVEL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_DELTA     = 3'd5;

  localparam logic [3:0] ACT_NONE          = 4'd0;
  localparam logic [3:0] ACT_GAIN_DOWN     = 4'd1;
  localparam logic [3:0] ACT_TIME_DOWN     = 4'd2;
  localparam logic [3:0] ACT_GAIN_UP       = 4'd3;
  localparam logic [3:0] ACT_TIME_UP       = 4'd4;
  localparam logic [3:0] ACT_SETTLED       = 4'd5;
  localparam logic [3:0] ACT_IN_RANGE      = 4'd6;
  localparam logic [3:0] ACT_SAT_LOWEST    = 4'd7;
  localparam logic [3:0] ACT_FAINT_HIGHEST = 4'd8;

  localparam logic [1:0] GAIN_LOW = 2'd0;
  localparam logic [1:0] GAIN_MAX = 2'd3;

  localparam logic [2:0] TIME_100MS = 3'd0;
  localparam logic [2:0] TIME_200MS = 3'd1;
  localparam logic [2:0] TIME_400MS = 3'd3;
  localparam logic [2:0] TIME_600MS = 3'd5;

  typedef struct packed {
    logic [15:0] ir_raw;
    logic [15:0] full_raw;
    logic        start_req;
  } in_word_t;

  typedef struct packed {
    logic [15:0]      ir_cal;
    logic [15:0]      full_cal;
    logic [15:0]      visible;
    logic [1:0]       gain_sel;
    logic [2:0]       time_sel;
    logic [3:0]       action;
    logic             done_res;
    logic [CNT_W-1:0] reading_index;
  } out_word_t;

  function automatic logic [2:0] time_down(input logic [2:0] t);
    case (t)
      TIME_600MS: time_down = TIME_400MS;
      TIME_400MS: time_down = TIME_200MS;
      default:    time_down = t;
    endcase
  endfunction

  function automatic logic [2:0] time_up(input logic [2:0] t);
    case (t)
      TIME_200MS: time_up = TIME_400MS;
      TIME_400MS: time_up = TIME_600MS;
      default:    time_up = t;
    endcase
  endfunction

endpackage

@@ hw/rtl/lsar_stream_if.sv @@
// Valid/ready stream interface carrying one word per handshake.
interface lsar_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/light_sensor_auto_ranging.sv @@
// Light sensor auto-ranging top level: calibration, visible count and gain/time stepping.
//
// Takes one reading word per clock unless stalled and returns one result word per reading,
// registered in stage B. The first stage holds the two 16x16 calibration multipliers and
// their saturation; the second stage compares against the ranging state (gain, time,
// last visible count, reading count) and updates it, so back-to-back readings see the
// state left by the one before. The pipeline stalls as a whole only while a result word
// waits and the sink is not ready. Configuration writes take effect at once and are
// expected only while no reading is in flight.
module light_sensor_auto_ranging #(
  parameter int unsigned MAX_READINGS     = 32,
  parameter int unsigned FACTOR_FRAC_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  lsar_stream_if.sink                    reading,
  lsar_stream_if.source                  result,
  input  logic                           cfg_we,
  input  logic [lsar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata
);

  logic        temp_cal_enable;
  logic [15:0] ir_factor;
  logic [15:0] full_factor;
  logic [15:0] saturation_level;
  logic [15:0] faint_level;
  logic [15:0] settle_delta;

  logic [1:0]                 gain_code;
  logic [2:0]                 time_code;
  logic signed [16:0]         last_visible;
  logic [lsar_pkg::CNT_W-1:0] reading_count;
  logic                       gain_lowered;

  logic        adv;
  logic        a_valid;
  logic [15:0] a_ir;
  logic [15:0] a_full;
  logic        a_start;
  logic        out_valid;
  lsar_pkg::out_word_t out_word;

  logic [31:0] prod_ir;
  logic [31:0] prod_full;
  logic [31:0] shr_ir;
  logic [31:0] shr_full;
  logic [15:0] cal_ir;
  logic [15:0] cal_full;

  logic [15:0]                vis;
  logic signed [17:0]         diff;
  logic [16:0]                diff_abs;
  logic                       settled;
  logic [lsar_pkg::CNT_W-1:0] cnt_base;
  logic [lsar_pkg::CNT_W-1:0] cnt_next;
  logic                       gl_base;
  logic [1:0]                 gain_next;
  logic [2:0]                 time_next;
  logic                       gl_next;
  logic [3:0]                 act;
  logic                       done;

  assign adv           = !out_valid || result.ready;
  assign reading.ready = adv;
  assign result.valid  = out_valid;
  assign result.data   = out_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal_enable  <= 1'b0;
      ir_factor        <= 16'd4096;
      full_factor      <= 16'd4096;
      saturation_level <= 16'd65000;
      faint_level      <= 16'd128;
      settle_delta     <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        lsar_pkg::REG_TEMP_CAL_ENABLE:  temp_cal_enable  <= cfg_wdata[0];
        lsar_pkg::REG_IR_FACTOR:        ir_factor        <= cfg_wdata;
        lsar_pkg::REG_FULL_FACTOR:      full_factor      <= cfg_wdata;
        lsar_pkg::REG_SATURATION_LEVEL: saturation_level <= cfg_wdata;
        lsar_pkg::REG_FAINT_LEVEL:      faint_level      <= cfg_wdata;
        lsar_pkg::REG_SETTLE_DELTA:     settle_delta     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage A: calibration multiply, shift and saturate, or raw pass-through when calibration is off
  always_comb begin
    prod_ir   = {16'b0, reading.data.ir_raw} * {16'b0, ir_factor};
    prod_full = {16'b0, reading.data.full_raw} * {16'b0, full_factor};
    shr_ir    = prod_ir >> FACTOR_FRAC_BITS;
    shr_full  = prod_full >> FACTOR_FRAC_BITS;
    cal_ir    = (|shr_ir[31:16]) ? 16'hFFFF : shr_ir[15:0];
    cal_full  = (|shr_full[31:16]) ? 16'hFFFF : shr_full[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= reading.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ir    <= temp_cal_enable ? cal_ir : reading.data.ir_raw;
      a_full  <= temp_cal_enable ? cal_full : reading.data.full_raw;
      a_start <= reading.data.start_req;
    end
  end

  // Stage B: ranging decision
  always_comb begin
    vis      = (a_full > a_ir) ? (a_full - a_ir) : 16'd1;
    diff     = $signed({2'b00, vis}) - 18'(last_visible);
    diff_abs = diff[17] ? 17'(-diff) : diff[16:0];
    settled  = diff_abs < {1'b0, settle_delta};

    cnt_base = a_start ? '0 : reading_count;
    cnt_next = (cnt_base < lsar_pkg::CNT_MAX) ? cnt_base + 1'b1 : cnt_base;
    gl_base  = a_start ? 1'b0 : gain_lowered;

    gain_next = gain_code;
    time_next = time_code;
    gl_next   = gl_base;
    act       = lsar_pkg::ACT_NONE;

    if (settled) begin
      act = lsar_pkg::ACT_SETTLED;
    end else if (a_full >= saturation_level || a_ir >= saturation_level) begin
      if (gain_code != lsar_pkg::GAIN_LOW) begin
        gain_next = gain_code - 1'b1;
        gl_next   = 1'b1;
        act       = lsar_pkg::ACT_GAIN_DOWN;
      end else if (time_code != lsar_pkg::TIME_100MS) begin
        time_next = lsar_pkg::time_down(time_code);
        gl_next   = 1'b1;
        act       = lsar_pkg::ACT_TIME_DOWN;
      end else begin
        act = lsar_pkg::ACT_SAT_LOWEST;
      end
    end else if (vis < faint_level) begin
      if (gl_base) begin
        act = lsar_pkg::ACT_NONE;
      end else if (gain_code != lsar_pkg::GAIN_MAX) begin
        gain_next = gain_code + 1'b1;
        act       = lsar_pkg::ACT_GAIN_UP;
      end else if (time_code != lsar_pkg::TIME_600MS) begin
        time_next = lsar_pkg::time_up(time_code);
        act       = lsar_pkg::ACT_TIME_UP;
      end else begin
        act = lsar_pkg::ACT_FAINT_HIGHEST;
      end
    end else begin
      act = lsar_pkg::ACT_IN_RANGE;
    end

    done = (act >= lsar_pkg::ACT_SETTLED) ||
           (cnt_next >= lsar_pkg::CNT_W'(MAX_READINGS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_code     <= lsar_pkg::GAIN_LOW;
      time_code     <= lsar_pkg::TIME_400MS;
      last_visible  <= -17'sd1;
      reading_count <= '0;
      gain_lowered  <= 1'b0;
      out_valid     <= 1'b0;
    end else if (adv) begin
      out_valid <= a_valid;
      if (a_valid) begin
        gain_code     <= gain_next;
        time_code     <= time_next;
        reading_count <= cnt_next;
        gain_lowered  <= gl_next;
        if (!settled) begin
          last_visible <= $signed({1'b0, vis});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid) begin
      out_word.ir_cal        <= a_ir;
      out_word.full_cal      <= a_full;
      out_word.visible       <= vis;
      out_word.gain_sel      <= gain_next;
      out_word.time_sel      <= time_next;
      out_word.action        <= act;
      out_word.done_res      <= done;
      out_word.reading_index <= cnt_next;
    end
  end

endmodule

@@ test/tb_light_sensor_auto_ranging.sv @@
// Self-checking testbench for the light sensor auto-ranging block.
`timescale 1ns / 1ps

module tb_light_sensor_auto_ranging;

  localparam int unsigned MAX_READ = 32;
  localparam int unsigned FRAC = 12;
  localparam int LATENCY = 2;
  localparam int WATCHDOG = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 80;

  typedef struct {
    bit          en;
    int unsigned ir_f;
    int unsigned full_f;
    int unsigned sat;
    int unsigned faint;
    int unsigned settle;
  } ranging_cfg_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [lsar_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_wdata;

  lsar_stream_if #(.word_t(lsar_pkg::in_word_t)) reading_if ();
  lsar_stream_if #(.word_t(lsar_pkg::out_word_t)) result_if ();

  light_sensor_auto_ranging #(
    .MAX_READINGS(MAX_READ),
    .FACTOR_FRAC_BITS(FRAC)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .reading(reading_if),
    .result(result_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Ranging state and register copies, reset values.
  logic [1:0] gain_q = lsar_pkg::GAIN_LOW;
  logic [2:0] time_q = lsar_pkg::TIME_400MS;
  int last_vis = -1;
  logic [lsar_pkg::CNT_W-1:0] rd_count = '0;
  bit lowered = 1'b0;
  bit cal_en = 1'b0;
  int unsigned ir_fac = 4096;
  int unsigned full_fac = 4096;
  int unsigned sat_lvl = 65000;
  int unsigned faint_lvl = 128;
  int unsigned settle_lvl = 10;

  lsar_pkg::in_word_t pending_readings[$];
  lsar_pkg::out_word_t expected_results[$];
  int errors = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_taken;
  int hold_left;
  int stall_cycles;
  int anchor = 100;

  function automatic logic [15:0] scale_count(logic [15:0] raw, int unsigned factor);
    logic [31:0] prod;
    prod = (32'(raw) * factor) >> FRAC;
    return (prod > 32'd65535) ? 16'hFFFF : prod[15:0];
  endfunction

  function automatic lsar_pkg::out_word_t step_ranging(lsar_pkg::in_word_t w);
    lsar_pkg::out_word_t r;
    logic [15:0] ir_c;
    logic [15:0] full_c;
    logic [15:0] vis;
    int diff;
    logic [3:0] act;
    if (w.start_req) begin
      rd_count = '0;
      lowered = 1'b0;
    end
    if (rd_count != lsar_pkg::CNT_MAX) rd_count = rd_count + 1'b1;
    ir_c = w.ir_raw;
    full_c = w.full_raw;
    if (cal_en) begin
      ir_c = scale_count(w.ir_raw, ir_fac);
      full_c = scale_count(w.full_raw, full_fac);
    end
    vis = (full_c > ir_c) ? full_c - ir_c : 16'd1;
    diff = int'(vis) - last_vis;
    if (diff < 0) diff = -diff;
    if (diff < int'(settle_lvl)) begin
      act = lsar_pkg::ACT_SETTLED;
    end else begin
      last_vis = int'(vis);
      if (full_c >= sat_lvl || ir_c >= sat_lvl) begin
        if (gain_q != lsar_pkg::GAIN_LOW) begin
          gain_q = gain_q - 1'b1;
          lowered = 1'b1;
          act = lsar_pkg::ACT_GAIN_DOWN;
        end else if (time_q != lsar_pkg::TIME_100MS) begin
          // only 600 -> 400 -> 200 moves; other codes stay
          case (time_q)
            lsar_pkg::TIME_600MS: time_q = lsar_pkg::TIME_400MS;
            lsar_pkg::TIME_400MS: time_q = lsar_pkg::TIME_200MS;
            default: ;
          endcase
          lowered = 1'b1;
          act = lsar_pkg::ACT_TIME_DOWN;
        end else begin
          act = lsar_pkg::ACT_SAT_LOWEST;
        end
      end else if (vis < faint_lvl) begin
        if (lowered) begin
          act = lsar_pkg::ACT_NONE;
        end else if (gain_q != lsar_pkg::GAIN_MAX) begin
          gain_q = gain_q + 1'b1;
          act = lsar_pkg::ACT_GAIN_UP;
        end else if (time_q != lsar_pkg::TIME_600MS) begin
          case (time_q)
            lsar_pkg::TIME_200MS: time_q = lsar_pkg::TIME_400MS;
            lsar_pkg::TIME_400MS: time_q = lsar_pkg::TIME_600MS;
            default: ;
          endcase
          act = lsar_pkg::ACT_TIME_UP;
        end else begin
          act = lsar_pkg::ACT_FAINT_HIGHEST;
        end
      end else begin
        act = lsar_pkg::ACT_IN_RANGE;
      end
    end
    r.ir_cal = ir_c;
    r.full_cal = full_c;
    r.visible = vis;
    r.gain_sel = gain_q;
    r.time_sel = time_q;
    r.action = act;
    r.done_res = (act >= lsar_pkg::ACT_SETTLED) || (rd_count >= MAX_READ);
    r.reading_index = rd_count;
    return r;
  endfunction

  function automatic logic [15:0] clip16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic lsar_pkg::in_word_t reading_word(int ir, int full, bit start);
    lsar_pkg::in_word_t w;
    w.ir_raw = clip16(ir);
    w.full_raw = clip16(full);
    w.start_req = start;
    return w;
  endfunction

  // Random reading biased toward saturated, faint, settled and in-range light.
  function automatic lsar_pkg::in_word_t next_reading(bit start);
    int ir;
    int full;
    int pick;
    int s;
    lsar_pkg::in_word_t w;
    pick = $urandom_range(99);
    ir = $urandom_range(65535);
    full = $urandom_range(65535);
    s = int'(settle_lvl > 200 ? 200 : settle_lvl);
    if (pick < 15) begin
      if ($urandom_range(1)) ir = $urandom_range(65535, sat_lvl);
      else full = $urandom_range(65535, sat_lvl);
    end else if (pick < 35) begin
      ir = $urandom_range(60000);
      full = ir + int'($urandom_range(faint_lvl));
    end else if (pick < 55) begin
      ir = $urandom_range(30000);
      full = ir + anchor + int'($urandom_range(2 * s + 4)) - s - 2;
    end else if (pick < 80) begin
      ir = $urandom_range(20000);
      full = ir + int'($urandom_range(40000, faint_lvl));
    end
    w = reading_word(ir, full, start);
    anchor = (w.full_raw > w.ir_raw) ? int'(w.full_raw - w.ir_raw) : 1;
    return w;
  endfunction

  task automatic write_reg(logic [lsar_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    case (idx)
      lsar_pkg::REG_TEMP_CAL_ENABLE: cal_en = val[0];
      lsar_pkg::REG_IR_FACTOR: ir_fac = val & 32'hFFFF;
      lsar_pkg::REG_FULL_FACTOR: full_fac = val & 32'hFFFF;
      lsar_pkg::REG_SATURATION_LEVEL: sat_lvl = val & 32'hFFFF;
      lsar_pkg::REG_FAINT_LEVEL: faint_lvl = val & 32'hFFFF;
      lsar_pkg::REG_SETTLE_DELTA: settle_lvl = val & 32'hFFFF;
      default: ;
    endcase
  endtask

  task automatic apply_config(ranging_cfg_t c);
    write_reg(lsar_pkg::REG_TEMP_CAL_ENABLE, c.en);
    write_reg(lsar_pkg::REG_IR_FACTOR, c.ir_f);
    write_reg(lsar_pkg::REG_FULL_FACTOR, c.full_f);
    write_reg(lsar_pkg::REG_SATURATION_LEVEL, c.sat);
    write_reg(lsar_pkg::REG_FAINT_LEVEL, c.faint);
    write_reg(lsar_pkg::REG_SETTLE_DELTA, c.settle);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_readings.size() != 0 || reading_if.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Reading driver: holds a word until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      reading_if.valid <= 1'b0;
    end else begin
      if (reading_if.valid && reading_if.ready) begin
        expected_results.push_back(step_ranging(reading_if.data));
        void'(pending_readings.pop_front());
      end
      if (reading_if.valid && !reading_if.ready) begin
      end else if (pending_readings.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
        reading_if.valid <= 1'b1;
        reading_if.data <= pending_readings[0];
      end else begin
        reading_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin : result_mon
    lsar_pkg::out_word_t want;
    lsar_pkg::out_word_t got;
    if (rst) begin
      result_if.ready <= 1'b0;
      hold_taken <= 1'b0;
      hold_left <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        got = result_if.data;
        if (expected_results.size() == 0) begin
          $error("result word with no reading outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.ir_cal !== want.ir_cal) begin
            $error("ir_cal: expected %0d, actual %0d", want.ir_cal, got.ir_cal);
            errors++;
          end
          if (got.full_cal !== want.full_cal) begin
            $error("full_cal: expected %0d, actual %0d", want.full_cal, got.full_cal);
            errors++;
          end
          if (got.visible !== want.visible) begin
            $error("visible: expected %0d, actual %0d", want.visible, got.visible);
            errors++;
          end
          if (got.gain_sel !== want.gain_sel) begin
            $error("gain_sel: expected %0d, actual %0d", want.gain_sel, got.gain_sel);
            errors++;
          end
          if (got.time_sel !== want.time_sel) begin
            $error("time_sel: expected %0d, actual %0d", want.time_sel, got.time_sel);
            errors++;
          end
          if (got.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, got.action);
            errors++;
          end
          if (got.done_res !== want.done_res) begin
            $error("done_res: expected %0d, actual %0d", want.done_res, got.done_res);
            errors++;
          end
          if (got.reading_index !== want.reading_index) begin
            $error("reading_index: expected %0d, actual %0d",
                   want.reading_index, got.reading_index);
            errors++;
          end
        end
      end
      if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= HOLD_CYCLES;
        result_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((reading_if.valid && reading_if.ready) || (result_if.valid && result_if.ready)
                 || (pending_readings.size() == 0 && expected_results.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG) begin
      $display("light_sensor_auto_ranging test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    ranging_cfg_t plan[6];
    int items;
    int len;
    bit long_done;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = lsar_pkg::REG_TEMP_CAL_ENABLE;
    cfg_wdata = '0;
    reading_if.valid = 1'b0;
    reading_if.data = '0;
    result_if.ready = 1'b0;
    plan[0] = '{1'b0, 4096, 4096, 65000, 128, 10};
    plan[1] = '{1'b1, 4096, 4096, 65000, 128, 10};
    plan[2] = '{1'b1, 5000, 3000, 60000, 300, 4};
    plan[3] = '{1'b1, 65535, 0, 0, 0, 0};
    plan[4] = '{1'b1, 0, 65535, 65535, 65535, 65535};
    plan[5] = '{1'b1, $urandom_range(65535), $urandom_range(65535),
                $urandom_range(65535, 20000), $urandom_range(3000), $urandom_range(40)};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: ladder ends, thresholds, settle boundary, lowered gain
    @(negedge clk);
    pending_readings.push_back(reading_word(0, 0, 1));
    pending_readings.push_back(reading_word(65535, 65535, 0));
    pending_readings.push_back(reading_word(0, 65535, 0));
    pending_readings.push_back(reading_word(0, 20, 0));
    pending_readings.push_back(reading_word(100, 150, 1));
    pending_readings.push_back(reading_word(0, 20, 0));
    pending_readings.push_back(reading_word(0, 80, 0));
    pending_readings.push_back(reading_word(0, 20, 0));
    pending_readings.push_back(reading_word(0, 80, 0));
    pending_readings.push_back(reading_word(0, 20, 0));
    pending_readings.push_back(reading_word(1000, 5000, 0));
    pending_readings.push_back(reading_word(1000, 5005, 0));
    pending_readings.push_back(reading_word(65535, 0, 0));
    pending_readings.push_back(reading_word(0, 65000, 0));
    pending_readings.push_back(reading_word(64999, 64999, 0));
    pending_readings.push_back(reading_word(65000, 200, 0));
    pending_readings.push_back(reading_word(0, 64999, 0));
    pending_readings.push_back(reading_word(300, 427, 0));
    pending_readings.push_back(reading_word(0, 128, 1));
    pending_readings.push_back(reading_word(0, 117, 0));
    pending_readings.push_back(reading_word(0, 127, 0));
    pending_readings.push_back(reading_word(0, 136, 0));
    wait_drained();

    long_done = 1'b0;
    for (int p = 0; p < 6; p++) begin
      apply_config(plan[p]);
      calm = (p == 2);
      @(negedge clk);
      if (p == 2) hold_go = 1'b1;
      items = 0;
      while (items < PHASE_ITEMS) begin
        if (p == 1 && !long_done) begin
          len = 70;
          long_done = 1'b1;
        end else if ($urandom_range(9) == 0) begin
          len = $urandom_range(40, 30);
        end else begin
          len = $urandom_range(12, 1);
        end
        for (int i = 0; i < len; i++) pending_readings.push_back(next_reading(i == 0));
        items += len;
      end
      wait_drained();
    end
    calm = 1'b0;

    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("light_sensor_auto_ranging test passed");
    end else begin
      $display("light_sensor_auto_ranging test failed");
    end
    $finish;
  end

endmodule
